### hdl/dltq_pkg.sv
// Package for the delta-list timer queue: types, codes and pool constants.
package dltq_pkg;
  localparam int unsigned PoolEntriesDef = 8;
  localparam int unsigned MaxRes = 8;

  typedef enum logic [1:0] {
    FUNC_SCHED = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_PURGE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_EXPIRE = 2'd1,
    KIND_PURGE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE,
    ST_SCHED_HEAD,
    ST_SCHED_WALK,
    ST_SCHED_LINK,
    ST_TICK,
    ST_PURGE,
    ST_FINISH,
    ST_EMIT
  } state_e;

  // result buffered for the output side
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] task_id;
    logic        status;
  } res_t;
endpackage

### hdl/dltq_res_fifo.sv
// Result buffer: collects the results of one transaction, then drains them.
module dltq_res_fifo
  import dltq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  logic       wr_i,
  input  res_t       wr_data_i,
  input  logic       rd_i,
  output res_t       rd_data_o,
  output logic       rd_last_o,
  output logic       has_data_o,
  output logic       full_o
);
  localparam int unsigned AW = $clog2(MaxRes);
  res_t mem_q [MaxRes];
  logic [AW:0] wcnt_q, rptr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wcnt_q[AW-1:0]] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
      rptr_q <= '0;
    end else if (clr_i) begin
      wcnt_q <= '0;
      rptr_q <= '0;
    end else begin
      if (wr_i && !full_o) wcnt_q <= wcnt_q + 1'b1;
      if (rd_i && has_data_o) rptr_q <= rptr_q + 1'b1;
    end
  end

  assign full_o     = (wcnt_q == (AW+1)'(MaxRes));
  assign has_data_o = (rptr_q != wcnt_q);
  assign rd_data_o  = mem_q[rptr_q[AW-1:0]];
  assign rd_last_o  = (rptr_q + 1'b1 == wcnt_q);
endmodule

### hdl/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: pool, sequencer and shared add/subtract unit.
// One transaction at a time. The sequencer walks the linked list one entry per
// cycle through a single 33-bit add/subtract unit. After the accept cycle,
// schedule runs a free-slot search, a head compare, a walk along the list and
// a link step; tick removes expired entries from the head one by one, and purge
// visits every queued entry. A finish state follows, then the results (at most
// 8) are presented one per cycle while out_ready_i is high. in_ready_o is high
// only while the sequencer is idle.
module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES = PoolEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] delay_ms_i,
  input  logic [15:0] task_id_i,
  input  logic [7:0]  owner_a_i,
  input  logic [7:0]  owner_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_task_id_o,
  output logic        status_o,
  output logic [31:0] head_remaining_ms_o,
  output logic        queue_empty_o,
  output logic        last_o
);
  localparam int unsigned IW = $clog2(POOL_ENTRIES);
  localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [CW-1:0] FullCnt = CW'(POOL_ENTRIES);

  // pool storage; used bits reset, payload need not
  logic [31:0]   delta_q [POOL_ENTRIES];
  logic [15:0]   task_q  [POOL_ENTRIES];
  logic [7:0]    oa_q    [POOL_ENTRIES];
  logic [7:0]    ob_q    [POOL_ENTRIES];
  logic [IW-1:0] next_q  [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] used_q;
  logic [IW-1:0] head_q;
  logic [CW-1:0] cnt_q;

  state_e state_q, state_d;
  logic [1:0]  func_q;
  logic [31:0] val_q;
  logic [15:0] tsk_q;
  logic [7:0]  ia_q, ib_q;
  logic [IW-1:0] slot_q, ptr_q, prev_q, cur_q;
  logic [CW-1:0] k_q;
  logic          has_prev_q;
  logic [31:0]   head_rem_q;
  logic          empty_q;

  // shared add/subtract unit, operands chosen by the sequencer
  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_y;
  assign alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                         : ({1'b0, alu_a} + {1'b0, alu_b});

  logic   fifo_clr, fifo_wr, fifo_full, fifo_has, fifo_last;
  res_t   fifo_wdata, fifo_rdata;

  dltq_res_fifo u_fifo (
    .clk_i, .rst_ni,
    .clr_i(fifo_clr), .wr_i(fifo_wr), .wr_data_i(fifo_wdata),
    .rd_i(out_ready_i && state_q == ST_EMIT), .rd_data_o(fifo_rdata),
    .rd_last_o(fifo_last), .has_data_o(fifo_has), .full_o(fifo_full)
  );

  logic [IW-1:0] nx_ptr, nx_cur, nx_head;
  assign nx_ptr  = next_q[ptr_q];
  assign nx_cur  = next_q[cur_q];
  assign nx_head = next_q[head_q];
  logic purge_hit;
  assign purge_hit = (oa_q[cur_q] == ia_q) || (ob_q[cur_q] == ia_q);

  always_comb begin
    state_d    = state_q;
    alu_a      = val_q;
    alu_b      = delta_q[head_q];
    alu_sub    = 1'b1;
    fifo_clr   = 1'b0;
    fifo_wr    = 1'b0;
    fifo_wdata = '{kind: KIND_NONE, task_id: '0, status: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fifo_clr = 1'b1;
          case (func_e'(func_i))
            FUNC_SCHED: state_d = ST_FREE;
            FUNC_TICK:  state_d = ST_TICK;
            FUNC_PURGE: state_d = ST_PURGE;
            default:    state_d = ST_FINISH;
          endcase
        end
      end
      ST_FREE: begin
        if (cnt_q >= FullCnt) begin
          fifo_wr = 1'b1;
          fifo_wdata = '{kind: KIND_ACK, task_id: '0, status: 1'b1};
          state_d = ST_FINISH;
        end else if (!used_q[slot_q]) begin
          state_d = (cnt_q == '0) ? ST_SCHED_LINK : ST_SCHED_HEAD;
        end
      end
      ST_SCHED_HEAD: begin
        state_d = alu_y[32] ? ST_SCHED_LINK : ST_SCHED_WALK;
      end
      ST_SCHED_WALK: begin
        alu_b = delta_q[nx_ptr];
        if (k_q >= cnt_q || alu_y[32]) state_d = ST_SCHED_LINK;
      end
      ST_SCHED_LINK: begin
        alu_b = delta_q[nx_ptr];
        fifo_wr = 1'b1;
        fifo_wdata = '{kind: KIND_ACK, task_id: '0, status: 1'b0};
        state_d = ST_FINISH;
      end
      ST_TICK: begin
        if (cnt_q != '0 && !alu_y[32]) begin
          fifo_wr = !fifo_full;
          fifo_wdata = '{kind: KIND_EXPIRE, task_id: task_q[head_q], status: 1'b0};
        end else begin
          if (!fifo_has && !fifo_wr) fifo_wr = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_PURGE: begin
        alu_a = delta_q[nx_cur];
        alu_b = delta_q[cur_q];
        alu_sub = 1'b0;
        if (k_q == '0) begin
          if (!fifo_has) fifo_wr = 1'b1;
          state_d = ST_FINISH;
        end else if (purge_hit) begin
          fifo_wr = !fifo_full;
          fifo_wdata = '{kind: KIND_PURGE, task_id: task_q[cur_q], status: 1'b0};
        end
      end
      ST_FINISH: begin
        if (state_q == ST_FINISH && !fifo_has && func_q == FUNC_NOP) fifo_wr = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready_i && fifo_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      head_q <= '0;
      cnt_q  <= '0;
      empty_q <= 1'b1;
      head_rem_q <= '0;
    end else begin
      case (state_q)
        ST_SCHED_LINK: begin
          used_q[slot_q] <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
        ST_TICK: begin
          if (cnt_q != '0 && !alu_y[32]) begin
            used_q[head_q] <= 1'b0;
            cnt_q <= cnt_q - 1'b1;
            head_q <= (cnt_q > CW'(1)) ? nx_head : '0;
          end
        end
        ST_PURGE: begin
          if (k_q != '0 && purge_hit) begin
            used_q[cur_q] <= 1'b0;
            cnt_q <= cnt_q - 1'b1;
            if (!has_prev_q) head_q <= (k_q > CW'(1)) ? nx_cur : '0;
          end
        end
        ST_FINISH: begin
          empty_q <= (cnt_q == '0);
          head_rem_q <= (cnt_q == '0) ? 32'd0 : delta_q[head_q];
          if (cnt_q == '0) head_q <= '0;
        end
        default: ;
      endcase
      if (state_q == ST_SCHED_HEAD && alu_y[32]) head_q <= slot_q;
      if (state_q == ST_SCHED_LINK && cnt_q == '0) head_q <= slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        func_q <= func_i;
        val_q  <= delay_ms_i;
        tsk_q  <= task_id_i;
        ia_q   <= owner_a_i;
        ib_q   <= owner_b_i;
        slot_q <= '0;
        ptr_q  <= head_q;
        cur_q  <= head_q;
        k_q    <= cnt_q;
        has_prev_q <= 1'b0;
      end
      ST_FREE: begin
        if (used_q[slot_q] && cnt_q < FullCnt) slot_q <= slot_q + 1'b1;
        k_q <= CW'(1);
      end
      ST_SCHED_HEAD: begin
        if (alu_y[32]) begin
          delta_q[head_q] <= delta_q[head_q] - val_q;
          delta_q[slot_q] <= val_q;
          next_q[slot_q] <= head_q;
          task_q[slot_q] <= tsk_q;
          oa_q[slot_q] <= ia_q;
          ob_q[slot_q] <= ib_q;
        end else begin
          val_q <= alu_y[31:0];
        end
      end
      ST_SCHED_WALK: begin
        if (!(k_q >= cnt_q || alu_y[32])) begin
          ptr_q <= nx_ptr;
          val_q <= alu_y[31:0];
          k_q <= k_q + 1'b1;
        end
      end
      ST_SCHED_LINK: begin
        // head insert already done in ST_SCHED_HEAD
        if (cnt_q == '0 || head_q != slot_q) begin
          delta_q[slot_q] <= val_q;
          task_q[slot_q] <= tsk_q;
          oa_q[slot_q] <= ia_q;
          ob_q[slot_q] <= ib_q;
          next_q[slot_q] <= (cnt_q != '0 && k_q < cnt_q) ? nx_ptr : '0;
          if (cnt_q != '0) begin
            next_q[ptr_q] <= slot_q;
            if (k_q < cnt_q) delta_q[nx_ptr] <= delta_q[nx_ptr] - val_q;
          end
        end
      end
      ST_TICK: begin
        if (cnt_q != '0 && !alu_y[32]) begin
          val_q <= alu_y[31:0];
        end else if (cnt_q != '0) begin
          delta_q[head_q] <= delta_q[head_q] - val_q;
        end
      end
      ST_PURGE: begin
        if (k_q != '0) begin
          if (purge_hit) begin
            if (k_q > CW'(1))
              delta_q[nx_cur] <= alu_y[32] ? 32'hFFFF_FFFF : alu_y[31:0];
            if (has_prev_q) next_q[prev_q] <= nx_cur;
          end else begin
            prev_q <= cur_q;
            has_prev_q <= 1'b1;
          end
          cur_q <= nx_cur;
          k_q <= k_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o          = (state_q == ST_IDLE);
  assign out_valid_o         = (state_q == ST_EMIT) && fifo_has;
  assign kind_o              = fifo_rdata.kind;
  assign out_task_id_o       = fifo_rdata.task_id;
  assign status_o            = fifo_rdata.status;
  assign head_remaining_ms_o = head_rem_q;
  assign queue_empty_o       = empty_q;
  assign last_o              = fifo_last;
endmodule

### hdl/dltq_checker.sv
// Port-level checks for the delta-list timer queue, bound to the top level.
module dltq_checker
  import dltq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [15:0] out_task_id_o,
  input logic        status_o,
  input logic        queue_empty_o,
  input logic [31:0] head_remaining_ms_o,
  input logic        last_o
);
  // no new input while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready during output");
  // block goes busy right after taking a transaction
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
  // empty queue reports zero remaining time
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && queue_empty_o) |-> head_remaining_ms_o == 32'd0)
    else $error("empty queue with remaining time");
  // refusals only on schedule acks, with no task id
  a_status_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (kind_o == KIND_ACK && out_task_id_o == 16'd0))
    else $error("bad status");
  // head figures stay fixed across results of one transaction
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> $stable(head_remaining_ms_o))
    else $error("head time changed mid transaction");
endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
